>>> rtl/csvf_pkg.sv
// Shared types and constants for the CSV row field match filter.
`timescale 1ns / 1ps

package csvf_pkg;

    // Special text bytes
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] COMMA_BYTE   = 8'd44;

    // Saturation points of the per-row counters
    localparam logic [7:0] FIELD_SAT = 8'd255;
    localparam logic [4:0] CHAR_SAT  = 5'd31;

    // Port widths fixed by the interface
    localparam int unsigned OUT_OFS_W  = 24;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_COLUMN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_BYTES_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_BYTES_HIGH = 2'd3;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [7:0]       column;
        logic [4:0]       length;
        logic [15:0][7:0] bytes;   // byte 0 in bits 7:0
    } t_cfg;

    // Compare results handed to the row tracker
    typedef struct packed {
        logic end_hit;     // field ending now is the selected one and equal
        logic next_equal;  // still-equal flag after taking a data byte
    } t_cmp;

    // One completed-row result
    typedef struct packed {
        logic [OUT_OFS_W-1:0] row_number;
        logic [OUT_OFS_W-1:0] row_first_offset;
        logic [OUT_OFS_W-1:0] row_newline_offset;
        logic [7:0]           fields_in_row;
        logic                 row_matches;
    } t_result;

endpackage

>>> rtl/csv_row_field_match_filter.sv
// Top level of the CSV row field match filter.
`timescale 1ns / 1ps

// Takes CSV text at one byte per clock: a byte transfer happens whenever i_valid
// is high and o_stall is low. Each newline yields one row result on the output
// channel, registered in the output register or, while that is held, in the skid
// entry; commas and data bytes yield nothing. The output register is backed
// by one skid entry, so o_stall rises only once the consumer has held off for a
// result while another newline arrived. Row offsets and the row number are
// OFFSET_BITS wide internally and saturate; the compared field must equal the
// match string byte for byte and have exactly match_length bytes. Configuration
// writes take effect on the next byte and should be made while the block is idle.
module csv_row_field_match_filter
    import csvf_pkg::*;
#(
    parameter int unsigned MAX_MATCH_BYTES = 16,
    parameter int unsigned OFFSET_BITS     = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // text in
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_start_of_text,
    // row results out
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_OFS_W-1:0]  o_row_number,
    output logic [OUT_OFS_W-1:0]  o_row_first_offset,
    output logic [OUT_OFS_W-1:0]  o_row_newline_offset,
    output logic [7:0]            o_fields_in_row,
    output logic                  o_row_matches
);

    t_cfg    r_cfg;
    logic    accept;
    logic    res_valid;
    t_result res, out_res;
    logic    full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MATCH_COLUMN:     r_cfg.column       <= i_cfg_data[7:0];
                CFG_MATCH_LENGTH:     r_cfg.length       <= i_cfg_data[4:0];
                CFG_MATCH_BYTES_LOW:  r_cfg.bytes[7:0]   <= i_cfg_data;
                CFG_MATCH_BYTES_HIGH: r_cfg.bytes[15:8]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = full;
    assign accept  = i_valid & ~full;

    csvf_row_track #(
        .MAX_MATCH_BYTES (MAX_MATCH_BYTES),
        .OFFSET_BITS     (OFFSET_BITS)
    ) u_row_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_text_byte     (i_text_byte),
        .i_start_of_text (i_start_of_text),
        .i_cfg           (r_cfg),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    csvf_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .o_full      (full)
    );

    assign o_row_number         = out_res.row_number;
    assign o_row_first_offset   = out_res.row_first_offset;
    assign o_row_newline_offset = out_res.row_newline_offset;
    assign o_fields_in_row      = out_res.fields_in_row;
    assign o_row_matches        = out_res.row_matches;

    // A full skid entry implies the output register holds a result too
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> o_valid)
        else $error("skid entry full while output register empty");

    // A newline transfer always shows up as a pending result next cycle
    a_newline_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_text_byte == NEWLINE_BYTE) |=> o_valid)
        else $error("newline transfer produced no result");

    // Every reported row has at least one field
    a_fields_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fields_in_row != 8'd0))
        else $error("row result with zero fields");

    // A row never ends before it starts
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_first_offset <= o_row_newline_offset))
        else $error("row first offset past its newline offset");

endmodule

>>> rtl/csvf_field_cmp.sv
// Byte-wise comparison of the current field against the match string.
`timescale 1ns / 1ps

module csvf_field_cmp
    import csvf_pkg::*;
#(
    parameter int unsigned MAX_MATCH_BYTES = 16
) (
    input  logic [7:0] i_byte,
    input  logic [4:0] i_char_in_field,
    input  logic [7:0] i_field_index,
    input  logic       i_still_equal,
    input  t_cfg       i_cfg,
    output t_cmp       o_cmp
);

    localparam logic [4:0] MAX_BYTES = 5'(MAX_MATCH_BYTES);

    logic       len_ok;
    logic       char_in_range;
    logic [7:0] want_byte;

    // Lengths past the string store never match
    assign len_ok = (i_cfg.length <= MAX_BYTES);

    // Expected byte at this position; only used while position < length and < MAX_MATCH_BYTES
    assign char_in_range = (i_char_in_field < i_cfg.length) &&
                           (i_char_in_field < MAX_BYTES);
    assign want_byte     = i_cfg.bytes[i_char_in_field[3:0]];

    // Field end: selected column, exact length, all bytes equal so far
    assign o_cmp.end_hit = (i_field_index == i_cfg.column) &&
                           (i_char_in_field == i_cfg.length) &&
                           len_ok && i_still_equal;

    // Data byte: stays equal only inside the string and on a byte match
    assign o_cmp.next_equal = i_still_equal && char_in_range && (want_byte == i_byte);

endmodule

>>> rtl/csvf_row_track.sv
// Offset, row and field counters; forms one result per newline.
`timescale 1ns / 1ps

module csvf_row_track
    import csvf_pkg::*;
#(
    parameter int unsigned MAX_MATCH_BYTES = 16,
    parameter int unsigned OFFSET_BITS     = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    input  logic       i_start_of_text,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    logic [OFFSET_BITS-1:0] r_byte_offset, n_byte_offset;
    logic [OFFSET_BITS-1:0] r_row_first,   n_row_first;
    logic [OFFSET_BITS-1:0] r_row_count,   n_row_count;
    logic [7:0]             r_field_index, n_field_index;
    logic [4:0]             r_char,        n_char;
    logic                   r_equal,       n_equal;
    logic                   r_row_matched, n_row_matched;

    // State as seen by this byte, after an optional start-of-text clear
    logic [OFFSET_BITS-1:0] e_byte_offset, e_row_first, e_row_count;
    logic [7:0]             e_field_index;
    logic [4:0]             e_char;
    logic                   e_equal, e_row_matched;

    logic       is_nl, is_comma, matched_now;
    t_cmp       cmp;
    logic [31:0] ext_row_count, ext_row_first, ext_byte_offset;

    always_comb begin
        if (i_start_of_text) begin
            e_byte_offset = '0;
            e_row_first   = '0;
            e_row_count   = '0;
            e_field_index = '0;
            e_char        = '0;
            e_equal       = 1'b1;
            e_row_matched = 1'b0;
        end else begin
            e_byte_offset = r_byte_offset;
            e_row_first   = r_row_first;
            e_row_count   = r_row_count;
            e_field_index = r_field_index;
            e_char        = r_char;
            e_equal       = r_equal;
            e_row_matched = r_row_matched;
        end
    end

    csvf_field_cmp #(
        .MAX_MATCH_BYTES (MAX_MATCH_BYTES)
    ) u_field_cmp (
        .i_byte          (i_text_byte),
        .i_char_in_field (e_char),
        .i_field_index   (e_field_index),
        .i_still_equal   (e_equal),
        .i_cfg           (i_cfg),
        .o_cmp           (cmp)
    );

    assign is_nl       = (i_text_byte == NEWLINE_BYTE);
    assign is_comma    = (i_text_byte == COMMA_BYTE);
    assign matched_now = e_row_matched | ((is_nl | is_comma) & cmp.end_hit);

    // Next-state update for one byte
    always_comb begin
        n_byte_offset = sat_inc(e_byte_offset);
        n_row_first   = e_row_first;
        n_row_count   = e_row_count;
        n_field_index = e_field_index;
        n_char        = e_char;
        n_equal       = e_equal;
        n_row_matched = matched_now;
        if (is_comma) begin
            n_field_index = (e_field_index == FIELD_SAT) ? e_field_index
                                                         : e_field_index + 8'd1;
            n_char        = '0;
            n_equal       = 1'b1;
        end else if (is_nl) begin
            n_row_count   = sat_inc(e_row_count);
            n_row_first   = sat_inc(e_byte_offset);
            n_field_index = '0;
            n_char        = '0;
            n_equal       = 1'b1;
            n_row_matched = 1'b0;
        end else begin
            n_equal = cmp.next_equal;
            n_char  = (e_char == CHAR_SAT) ? e_char : e_char + 5'd1;
        end
    end

    // Result fields, widened or narrowed to the port width
    assign ext_row_count   = 32'(e_row_count);
    assign ext_row_first   = 32'(e_row_first);
    assign ext_byte_offset = 32'(e_byte_offset);

    assign o_res_valid              = i_accept & is_nl;
    assign o_res.row_number         = ext_row_count[OUT_OFS_W-1:0];
    assign o_res.row_first_offset   = ext_row_first[OUT_OFS_W-1:0];
    assign o_res.row_newline_offset = ext_byte_offset[OUT_OFS_W-1:0];
    assign o_res.fields_in_row      = (e_field_index == FIELD_SAT) ? FIELD_SAT
                                                                   : e_field_index + 8'd1;
    assign o_res.row_matches        = matched_now;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_row_first   <= '0;
            r_row_count   <= '0;
            r_field_index <= '0;
            r_char        <= '0;
            r_equal       <= 1'b1;
            r_row_matched <= 1'b0;
        end else if (i_accept) begin
            r_byte_offset <= n_byte_offset;
            r_row_first   <= n_row_first;
            r_row_count   <= n_row_count;
            r_field_index <= n_field_index;
            r_char        <= n_char;
            r_equal       <= n_equal;
            r_row_matched <= n_row_matched;
        end
    end

endmodule

>>> rtl/csvf_out_stage.sv
// Result register with a skid entry, so input keeps flowing under output stall.
`timescale 1ns / 1ps

module csvf_out_stage
    import csvf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_full
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    taken;

    assign taken   = r_out_valid & ~i_stall;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

    // Control: skid fills only when a new result meets a stalled output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (taken) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !taken) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (taken) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (taken) begin
                r_out <= r_skid;
            end
        end else if (i_res_valid) begin
            if (r_out_valid && !taken) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

endmodule
